FILE: design/brr_pkg.sv
// shared types and constants for the brr adpcm block decoder
package brr_pkg;

    // transfer payloads
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic signed [14:0] sample;
        logic               last;
        logic               block_done;
        logic               end_flag;
        logic               loop_flag;
    } t_out_item;

    // prediction filter codes from header bits 3..2
    typedef enum logic [1:0] {
        FILT_NONE = 2'd0,
        FILT_ONE  = 2'd1,
        FILT_TWO  = 2'd2,
        FILT_THR  = 2'd3
    } t_filter;

    // working width of the nibble decode sum
    localparam int unsigned ACC_W = 20;

    // block layout: header then data bytes one to eight
    localparam logic [3:0] POS_HEADER = 4'd0;
    localparam logic [3:0] POS_FIRST  = 4'd1;
    localparam logic [3:0] POS_LAST   = 4'd8;

    // largest shift that is applied as is
    localparam logic [3:0] SHIFT_MAX = 4'd12;

    localparam logic signed [ACC_W-1:0] LARGE_SHIFT_NEG = -20'sd2048;
    localparam logic signed [ACC_W-1:0] SAT_MAX         = 20'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_MIN         = -20'sd32768;

endpackage

FILE: design/brr_nib_dec.sv
// one-nibble adpcm decode: scale, filter prediction, clamp and wrap
module brr_nib_dec (
    input  logic [3:0]         i_nibble,
    input  logic [3:0]         i_shift,
    input  brr_pkg::t_filter   i_filter,
    input  logic signed [14:0] i_old,
    input  logic signed [14:0] i_older,
    output logic signed [14:0] o_sample
);

    logic signed [brr_pkg::ACC_W-1:0] nx;
    logic signed [brr_pkg::ACC_W-1:0] scaled;
    logic signed [brr_pkg::ACC_W-1:0] base;
    logic signed [brr_pkg::ACC_W-1:0] p1;
    logic signed [brr_pkg::ACC_W-1:0] p2;
    logic signed [brr_pkg::ACC_W-1:0] neg3_p1;
    logic signed [brr_pkg::ACC_W-1:0] neg13_p1;
    logic signed [brr_pkg::ACC_W-1:0] x3_p2;
    logic signed [brr_pkg::ACC_W-1:0] pred;
    logic signed [brr_pkg::ACC_W-1:0] sum;
    logic signed [brr_pkg::ACC_W-1:0] clamped;

    assign nx = $signed({{(brr_pkg::ACC_W-4){i_nibble[3]}}, i_nibble});
    assign p1 = brr_pkg::ACC_W'(i_old);
    assign p2 = brr_pkg::ACC_W'(i_older);

    // small constant multiples as shift-add
    assign neg3_p1  = -((p1 <<< 1) + p1);
    assign neg13_p1 = -((p1 <<< 3) + (p1 <<< 2) + p1);
    assign x3_p2    = (p2 <<< 1) + p2;

    always_comb begin
        scaled = nx <<< i_shift;
        if (i_shift <= brr_pkg::SHIFT_MAX) begin
            base = scaled >>> 1;
        end else begin
            base = i_nibble[3] ? brr_pkg::LARGE_SHIFT_NEG : '0;
        end
    end

    always_comb begin
        case (i_filter)
            brr_pkg::FILT_NONE: pred = '0;
            brr_pkg::FILT_ONE:  pred = p1 + ((-p1) >>> 4);
            brr_pkg::FILT_TWO:  pred = (p1 <<< 1) + (neg3_p1 >>> 5) - p2 + (p2 >>> 4);
            brr_pkg::FILT_THR:  pred = (p1 <<< 1) + (neg13_p1 >>> 6) - p2 + (x3_p2 >>> 4);
            default:            pred = '0;
        endcase
    end

    assign sum = base + pred;

    // clamp to 16 bits, then keep the low 15 bits
    always_comb begin
        if (sum > brr_pkg::SAT_MAX) begin
            clamped = brr_pkg::SAT_MAX;
        end else if (sum < brr_pkg::SAT_MIN) begin
            clamped = brr_pkg::SAT_MIN;
        end else begin
            clamped = sum;
        end
    end

    assign o_sample = clamped[14:0];

endmodule

FILE: design/brr_adpcm_block_decoder.sv
// top level of the brr adpcm block decoder
// Takes a byte stream of 9-byte blocks (one header byte, then eight data bytes)
// and returns two 15-bit samples per data byte, high nibble first. A header
// byte is absorbed and gives no transfer; a data byte occupies the input
// register until both nibbles are decoded, because each nibble's prediction
// needs the sample decoded just before it and the single decode unit closes
// that history loop once per cycle. Sustained rate is one sample per cycle
// while data bytes are held and the result side does not stall. Results sit in
// an output register; a stall on the result side holds the current data byte
// in the input register and stalls the input until the pending sample can move
// on. restart clears the history and forces the byte to be read as a header,
// dropping any partial block.
module brr_adpcm_block_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  brr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output brr_pkg::t_out_item o_out_item
);

    // input register
    logic              r_in_valid;
    brr_pkg::t_in_item r_in_item;
    logic              r_lo;          // low nibble of held byte is next

    // block state
    logic [3:0]         r_pos;
    logic [3:0]         r_shift;
    brr_pkg::t_filter   r_filter;
    logic [1:0]         r_flags;      // bit 0 end, bit 1 loop
    logic signed [14:0] r_p1;
    logic signed [14:0] r_p2;

    // result register
    logic               r_out_valid;
    brr_pkg::t_out_item r_out_item;

    logic               out_free;
    logic               is_hdr;
    logic               do_hdr;
    logic               do_smp;
    logic               consume;
    logic               accept;
    logic [3:0]         nibble;
    logic signed [14:0] dec_sample;
    logic [3:0]         n_pos;

    // result register can take a sample this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // restart or an out-of-block position reads the byte as a header
    assign is_hdr  = r_in_item.restart || (r_pos == brr_pkg::POS_HEADER)
                     || (r_pos > brr_pkg::POS_LAST);
    assign do_hdr  = r_in_valid && is_hdr;
    assign do_smp  = r_in_valid && !is_hdr && out_free;
    assign consume = do_hdr || (do_smp && r_lo);

    assign o_in_stall = r_in_valid && !consume;
    assign accept     = i_in_valid && !o_in_stall;

    assign nibble = r_lo ? r_in_item.data_byte[3:0] : r_in_item.data_byte[7:4];

    brr_nib_dec u_dec (
        .i_nibble (nibble),
        .i_shift  (r_shift),
        .i_filter (r_filter),
        .i_old    (r_p1),
        .i_older  (r_p2),
        .o_sample (dec_sample)
    );

    // position after the low nibble of a data byte
    assign n_pos = (r_pos == brr_pkg::POS_LAST) ? brr_pkg::POS_HEADER : r_pos + 4'd1;

    // input register: a new transfer lands as soon as the held byte is done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= i_in_item;
        end
    end

    // header decode and sample history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo     <= 1'b0;
            r_pos    <= brr_pkg::POS_HEADER;
            r_shift  <= '0;
            r_filter <= brr_pkg::FILT_NONE;
            r_flags  <= '0;
            r_p1     <= '0;
            r_p2     <= '0;
        end else if (do_hdr) begin
            r_lo     <= 1'b0;
            r_pos    <= brr_pkg::POS_FIRST;
            r_shift  <= r_in_item.data_byte[7:4];
            r_filter <= brr_pkg::t_filter'(r_in_item.data_byte[3:2]);
            r_flags  <= r_in_item.data_byte[1:0];
            if (r_in_item.restart) begin
                r_p1 <= '0;
                r_p2 <= '0;
            end
        end else if (do_smp) begin
            r_p2 <= r_p1;
            r_p1 <= dec_sample;
            r_lo <= !r_lo;
            if (r_lo) begin
                r_pos <= n_pos;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_smp) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_smp) begin
            r_out_item.sample     <= dec_sample;
            r_out_item.last       <= r_lo;
            r_out_item.block_done <= r_lo && (r_pos == brr_pkg::POS_LAST);
            r_out_item.end_flag   <= r_flags[0];
            r_out_item.loop_flag  <= r_flags[1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: tb/sv/brr_adpcm_block_decoder_test.sv
// self-checking testbench for the brr adpcm block decoder
`timescale 1ns / 100ps

module brr_adpcm_block_decoder_test;

    // sample predictor and expected-sample store
    class brr_sample_predictor;
        logic signed [14:0] hist_old;
        logic signed [14:0] hist_older;
        logic [3:0]         shift_q;
        brr_pkg::t_filter   filt_q;
        logic [1:0]         flags_q;    // bit 0 end, bit 1 loop
        logic [3:0]         pos_q;
        brr_pkg::t_out_item expected_samples[$];
        int                 errors;

        function new();
            hist_old   = '0;
            hist_older = '0;
            shift_q    = '0;
            filt_q     = brr_pkg::FILT_NONE;
            flags_q    = '0;
            pos_q      = brr_pkg::POS_HEADER;
            errors     = 0;
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%0t: %s", $realtime, msg);
            end
        endfunction

        // one nibble through shift, prediction, clamp and 15-bit wrap
        function logic signed [14:0] decode_nibble(logic [3:0] nib);
            int n;
            int s;
            int p1;
            int p2;
            n  = int'(nib);
            p1 = int'(hist_old);
            p2 = int'(hist_older);
            if (n >= 8) begin
                n -= 16;
            end
            if (shift_q <= brr_pkg::SHIFT_MAX) begin
                s = (n <<< shift_q) >>> 1;
            end else begin
                s = (n < 0) ? int'(brr_pkg::LARGE_SHIFT_NEG) : 0;
            end
            case (filt_q)
                brr_pkg::FILT_ONE: begin
                    s += p1 + ((-p1) >>> 4);
                end
                brr_pkg::FILT_TWO: begin
                    s += 2 * p1 + ((-3 * p1) >>> 5) - p2 + (p2 >>> 4);
                end
                brr_pkg::FILT_THR: begin
                    s += 2 * p1 + ((-13 * p1) >>> 6) - p2 + ((3 * p2) >>> 4);
                end
                default: begin
                end
            endcase
            if (s > int'(brr_pkg::SAT_MAX)) begin
                s = int'(brr_pkg::SAT_MAX);
            end
            if (s < int'(brr_pkg::SAT_MIN)) begin
                s = int'(brr_pkg::SAT_MIN);
            end
            hist_older = hist_old;
            hist_old   = s[14:0];
            return s[14:0];
        endfunction

        // accepted input byte: update state, queue the samples it yields
        function void note_byte(brr_pkg::t_in_item it);
            brr_pkg::t_out_item hi_smp;
            brr_pkg::t_out_item lo_smp;
            logic               done;
            if (it.restart) begin
                hist_old   = '0;
                hist_older = '0;
                pos_q      = brr_pkg::POS_HEADER;
            end
            if (pos_q == brr_pkg::POS_HEADER || pos_q > brr_pkg::POS_LAST) begin
                shift_q = it.data_byte[7:4];
                filt_q  = brr_pkg::t_filter'(it.data_byte[3:2]);
                flags_q = it.data_byte[1:0];
                pos_q   = brr_pkg::POS_FIRST;
                return;
            end
            done              = (pos_q == brr_pkg::POS_LAST);
            hi_smp.sample     = decode_nibble(it.data_byte[7:4]);
            hi_smp.last       = 1'b0;
            hi_smp.block_done = 1'b0;
            hi_smp.end_flag   = flags_q[0];
            hi_smp.loop_flag  = flags_q[1];
            lo_smp.sample     = decode_nibble(it.data_byte[3:0]);
            lo_smp.last       = 1'b1;
            lo_smp.block_done = done;
            lo_smp.end_flag   = flags_q[0];
            lo_smp.loop_flag  = flags_q[1];
            expected_samples.push_back(hi_smp);
            expected_samples.push_back(lo_smp);
            pos_q = done ? brr_pkg::POS_HEADER : pos_q + 4'd1;
        endfunction

        function void check_sample(brr_pkg::t_out_item got);
            brr_pkg::t_out_item exp_smp;
            if (expected_samples.size() == 0) begin
                flag_error($sformatf("unexpected sample %0d last %b done %b end %b loop %b",
                    got.sample, got.last, got.block_done, got.end_flag, got.loop_flag));
                return;
            end
            exp_smp = expected_samples.pop_front();
            if (got.sample !== exp_smp.sample || got.last !== exp_smp.last ||
                got.block_done !== exp_smp.block_done ||
                got.end_flag !== exp_smp.end_flag || got.loop_flag !== exp_smp.loop_flag) begin
                flag_error($sformatf({"mismatch: expected sample %0d last %b done %b end %b ",
                    "loop %b, got sample %0d last %b done %b end %b loop %b"},
                    exp_smp.sample, exp_smp.last, exp_smp.block_done, exp_smp.end_flag,
                    exp_smp.loop_flag, got.sample, got.last, got.block_done, got.end_flag,
                    got.loop_flag));
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    brr_pkg::t_in_item  in_item;
    logic               out_valid;
    logic               out_stall;
    brr_pkg::t_out_item out_item;

    brr_sample_predictor predictor;
    int                  bytes_sent;
    bit                  calm;          // no gaps and no new stall runs while set
    int                  stall_run;

    brr_adpcm_block_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #5 clk = ~clk;

    // idle length before an input transfer: mostly none, some short, a few long
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    // drive one byte, starting and ending at a falling edge
    task automatic send_byte(input logic [7:0] data, input logic restart);
        brr_pkg::t_in_item it;
        int                gap;
        it.data_byte = data;
        it.restart   = restart;
        gap          = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do @(posedge clk); while (in_stall);
        predictor.note_byte(it);
        bytes_sent++;
        @(negedge clk);
    endtask

    // header followed by a number of random data bytes
    task automatic send_block(input logic [7:0] header, input logic restart, input int n_data);
        send_byte(header, restart);
        repeat (n_data) send_byte(8'($urandom), 1'b0);
    endtask

    // result-side stall: runs of random length; a run that starts while calm has no stall
    always @(negedge clk) begin
        if (stall_run == 0) begin
            if (calm || !rst_n) begin
                out_stall = 1'b0;
                stall_run = 1;
            end else begin
                out_stall = ($urandom_range(0, 99) < 35);
                stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                        : $urandom_range(1, 3);
            end
        end
        stall_run--;
    end

    // every sample transfer is checked against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            predictor.check_sample(out_item);
        end
    end

    // hard limit on the whole run
    initial begin
        #20_000_000;
        $display("brr_adpcm_block_decoder_test failed");
        $finish;
    end

    initial begin
        bit truncated;
        int n_data;
        predictor  = new();
        bytes_sent = 0;
        calm       = 1'b0;
        stall_run  = 0;
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        out_stall  = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed: nibble extremes, every filter, shifts at and past the clamp,
        // both flags, restart cutting a block, header after a full block
        send_byte(8'h00, 1'b1);             // shift 0, no filter, restart on a header
        send_byte(8'h87, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hC3, 1'b1);             // shift 12, end and loop, mid-block restart
        send_byte(8'h78, 1'b0);
        send_byte(8'hD4, 1'b1);             // shift 13: large-shift clamp, filter one
        send_byte(8'h8F, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'hF9, 1'b1);             // shift 15, filter two, end flag
        send_byte(8'h9A, 1'b0);
        send_byte(8'hCE, 1'b1);             // shift 12, filter three, loop flag
        repeat (8) send_byte(8'h77, 1'b0);  // full block, history runs into saturation
        send_byte(8'hCD, 1'b0);             // next header without restart, history kept
        send_byte(8'h88, 1'b0);
        send_byte(8'h88, 1'b0);

        // random blocks: mostly well formed, some cut short by a restart
        truncated = 1'b1;
        while (bytes_sent < 600) begin
            calm   = ($urandom_range(0, 5) == 0);
            n_data = ($urandom_range(0, 99) < 85) ? 8 : $urandom_range(0, 7);
            send_block(8'($urandom), truncated || ($urandom_range(0, 5) == 0), n_data);
            // a short block is usually followed by a restart, sometimes by plain bytes
            truncated = (n_data != 8) && ($urandom_range(0, 3) != 0);
        end
        calm     = 1'b0;
        in_valid = 1'b0;

        while (predictor.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (predictor.errors == 0 && predictor.pending() == 0) begin
            $display("brr_adpcm_block_decoder_test passed");
        end else begin
            $display("brr_adpcm_block_decoder_test failed");
        end
        $finish;
    end

endmodule
